### design/action_datagram_receive_parser_core_assert.svh
// Assertion macros used by the datagram receive parser top level.
`ifndef ACTION_DATAGRAM_RECEIVE_PARSER_CORE_ASSERT_SVH
`define ACTION_DATAGRAM_RECEIVE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ADRP_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
	else $error("adrp assertion failed");

// Next-cycle implication, disabled during reset.
`define ADRP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
	else $error("adrp assertion failed");

`endif

### design/adrp_pkg.sv
// Package with types, codes and constants of the datagram receive parser.
`timescale 1ns / 1ps
package adrp_pkg;

	localparam int NUM_PLAYERS      = 8;
	localparam int NUM_HOSTS        = 8;
	localparam int MASK_BYTES_LIMIT = 4;

	localparam int PLAYER_W = 3;
	localparam int HOST_W   = 3;
	localparam int PHOST_W  = 7;
	localparam int MASK_W   = 8 * (MASK_BYTES_LIMIT - 1);
	localparam int PADDR_W  = 3;

	localparam logic [MASK_W-1:0] PLAYER_MASK =
		MASK_W'((64'd1 << NUM_PLAYERS) - 64'd1);
	localparam logic [PLAYER_W-1:0] LAST_PLAYER = PLAYER_W'(NUM_PLAYERS - 1);
	localparam logic [PHOST_W-1:0]  HOST_LIMIT  = PHOST_W'(NUM_HOSTS);

	localparam logic [15:0] HDR_PING     = 16'hFFFF;
	localparam logic [15:0] HDR_RESERVED = 16'hFFFE;
	localparam logic [7:0]  FINISH_BYTE  = 8'hFF;

	// Register index taken from the word address
	localparam logic REG_MASK_BYTES = 1'b0;
	localparam logic REG_ABORT      = 1'b1;

	// Byte position within a datagram
	localparam logic [1:0] POS_HDR_LO = 2'd0;
	localparam logic [1:0] POS_HDR_HI = 2'd1;
	localparam logic [1:0] POS_BODY_A = 2'd2;
	localparam logic [1:0] POS_BODY_B = 2'd3;

	typedef enum logic [2:0] {
		EVT_ACTION   = 3'd0,
		EVT_FINISH   = 3'd1,
		EVT_IGNORE   = 3'd2,
		EVT_LOSS     = 3'd3,
		EVT_PING     = 3'd4,
		EVT_PING_END = 3'd5,
		EVT_PARSED   = 3'd6
	} event_kind_t;

	typedef enum logic [1:0] {
		DG_FRAMES   = 2'd0,
		DG_PING     = 2'd1,
		DG_RESERVED = 2'd2
	} dgram_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_PRIM = 2'd1,
		ST_TAIL = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] mask_bytes;
		logic       abort_on_loss;
	} cfg_t;

	typedef struct packed {
		logic                load_in;
		logic                emit_prim;
		logic                emit_tail;
		logic                last;
		logic [PLAYER_W-1:0] act_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_prim;
		logic prim_multi;
		logic has_tail;
		logic out_free;
	} dp_stat_t;

endpackage

### design/action_datagram_receive_parser_core.sv
// Top level of the datagram receive parser: registers, controller, datapath.
//
// Input channel: one datagram byte per transaction (command, data_byte,
// last_byte) on in_valid / in_stall. command high reports an empty datagram.
// Output channel: result transactions on out_valid / out_stall; last_of_run
// marks the final result caused by one input byte. Unused fields read zero.
// Config: APB-style, mask_bytes at 0x0, abort_on_loss at 0x4; write only
// while the block is idle.
// Flow: a byte is taken, then its primary results are loaded one at a time,
// then the closing result, if any (up to 9 results, all players of a
// matched frame plus parsed). The controller passes through its primary
// state also when there are no primary results, before any closing parsed
// or ping end. The controller sequences results one at a time through the
// single output register.
// When the receiver stalls, the held result stays in place and the
// controller waits; input stays stalled until the last result of the item
// has been loaded into the output register.
// Reset clears parse state, expects frame time 1 and sets mask_bytes to 1.
`timescale 1ns / 1ps
`include "action_datagram_receive_parser_core_assert.svh"
module action_datagram_receive_parser_core import adrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         event_kind,
	output logic [15:0]        game_time,
	output logic [2:0]         player_index,
	output logic [7:0]         action_byte,
	output logic [2:0]         host_index,
	output logic [15:0]        ping_time,
	output logic [15:0]        first_time,
	output logic [15:0]        next_time,
	output logic               last_of_run
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	adrp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	adrp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.game_time    (game_time),
		.player_index (player_index),
		.action_byte  (action_byte),
		.host_index   (host_index),
		.ping_time    (ping_time),
		.first_time   (first_time),
		.next_time    (next_time),
		.last_of_run  (last_of_run)
	);

	// A result is only loaded when the output register is free
	`ADRP_ASSERT_IMPLY(a_emit_free, clk, arst_n, cmd.emit_prim || cmd.emit_tail, !out_valid || !out_stall)
	// An accepted byte keeps the input stalled while its results go out
	`ADRP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// The closing result returns the block to accepting input
	`ADRP_ASSERT_NEXT(a_idle_after_tail, clk, arst_n, cmd.emit_tail, !in_stall)

endmodule

### design/adrp_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module adrp_regs import adrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [1:0] mask_bytes_q;
	logic       abort_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_bytes_q <= 2'd1;
			abort_q      <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MASK_BYTES: mask_bytes_q <= pwdata[1:0];
				REG_ABORT:      abort_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_MASK_BYTES: prdata = {30'd0, mask_bytes_q};
			REG_ABORT:      prdata = {31'd0, abort_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.mask_bytes    = mask_bytes_q;
	assign cfg.abort_on_loss = abort_q;

endmodule

### design/adrp_ctrl.sv
// Controller that accepts bytes and sequences the result transactions.
`timescale 1ns / 1ps
module adrp_ctrl import adrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t         state_q, state_n;
	logic [PLAYER_W-1:0] idx_q, idx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		cmd      = '0;
		cmd.act_idx = idx_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				// Take one byte and let the datapath plan its results
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = ST_PRIM;
				end
			end
			ST_PRIM: begin
				if (!stat.has_prim) begin
					state_n = stat.has_tail ? ST_TAIL : ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit_prim = 1'b1;
					// Walk every player for a matched frame
					if (stat.prim_multi && idx_q != LAST_PLAYER) begin
						idx_n = idx_q + PLAYER_W'(1);
					end else begin
						idx_n    = '0;
						cmd.last = !stat.has_tail;
						state_n  = stat.has_tail ? ST_TAIL : ST_IDLE;
					end
				end
			end
			ST_TAIL: begin
				if (!stat.has_tail) begin
					state_n = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit_tail = 1'b1;
					cmd.last      = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

### design/adrp_dpath.sv
// Datapath: parse state, pending results and the output register.
`timescale 1ns / 1ps
module adrp_dpath import adrp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  ctrl_cmd_t     cmd,
	output dp_stat_t      stat,
	input  logic          command,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [2:0]    event_kind,
	output logic [15:0]   game_time,
	output logic [2:0]    player_index,
	output logic [7:0]    action_byte,
	output logic [2:0]    host_index,
	output logic [15:0]   ping_time,
	output logic [15:0]   first_time,
	output logic [15:0]   next_time,
	output logic          last_of_run
);

	// Parse state
	logic [1:0]         pos_q, pos_n;
	logic [7:0]         hlo_q, hlo_n;
	dgram_kind_t        kind_q, kind_n;
	logic [15:0]        ftime_q, ftime_n;
	logic [15:0]        exp_q, exp_n;
	logic [MASK_W-1:0]  mask_q, mask_n;
	logic [1:0]         cnt_q, cnt_n;
	logic               fin_q, fin_n;
	logic               inact_q, inact_n;
	logic [7:0]         acts_q [NUM_PLAYERS];
	logic [7:0]         acts_n [NUM_PLAYERS];
	logic [PHOST_W-1:0] host_q, host_n;
	logic [7:0]         plow_q, plow_n;
	logic               skip_q, skip_n;
	logic [15:0]        held_q, held_n;

	// Pending results of the last accepted byte
	logic               pv_q, pv_n;
	event_kind_t        pk_q, pk_n;
	logic [15:0]        ptime_q, ptime_n;
	logic [HOST_W-1:0]  phost_q, phost_n;
	logic [15:0]        pping_q, pping_n;
	logic [7:0]         snap_q [NUM_PLAYERS];
	logic [7:0]         snap_n [NUM_PLAYERS];
	logic               tv_q, tv_n;
	event_kind_t        tk_q, tk_n;
	logic [15:0]        tfirst_q, tfirst_n;
	logic [15:0]        tnext_q, tnext_n;

	// Output register
	logic               ov_q;
	event_kind_t        ok_q, ok_n;
	logic [15:0]        ogt_q, ogt_n;
	logic [2:0]         opl_q, opl_n;
	logic [7:0]         oact_q, oact_n;
	logic [2:0]         ohost_q, ohost_n;
	logic [15:0]        oping_q, oping_n;
	logic [15:0]        ofirst_q, ofirst_n;
	logic [15:0]        onext_q, onext_n;
	logic               olast_q;

	// Scratch for the byte update
	logic [15:0]        hdr;
	logic [1:0]         mb;
	logic [1:0]         cnt_inc;
	logic [MASK_W-1:0]  mask_or;
	logic [MASK_W-1:0]  one_hot;
	logic [MASK_W-1:0]  mask_left;
	logic               frame_done;
	logic               frame_clr;
	logic               parse_clr;

	assign hdr     = {data_byte, hlo_q};
	assign mb      = (cfg.mask_bytes == 2'd0) ? 2'd1 : cfg.mask_bytes;
	assign cnt_inc = cnt_q + 2'd1;
	assign mask_or = mask_q | MASK_W'({24'd0, data_byte} << {cnt_q, 3'b000});
	assign one_hot = mask_q & (~mask_q + MASK_W'(1));
	assign mask_left = mask_q & ~one_hot;

	// Next parse state and the results planned for this byte
	always_comb begin
		pos_n   = pos_q;
		hlo_n   = hlo_q;
		kind_n  = kind_q;
		ftime_n = ftime_q;
		exp_n   = exp_q;
		mask_n  = mask_q;
		cnt_n   = cnt_q;
		fin_n   = fin_q;
		inact_n = inact_q;
		acts_n  = acts_q;
		host_n  = host_q;
		plow_n  = plow_q;
		skip_n  = skip_q;
		held_n  = held_q;
		pv_n    = 1'b0;
		pk_n    = EVT_PING_END;
		ptime_n = ftime_q;
		phost_n = host_q[HOST_W-1:0];
		pping_n = {data_byte, plow_q};
		snap_n  = acts_q;
		tv_n    = 1'b0;
		tk_n    = EVT_PING_END;
		tfirst_n = held_q;
		tnext_n  = ftime_q;
		frame_done = 1'b0;
		frame_clr  = 1'b0;
		parse_clr  = 1'b0;

		if (command) begin
			// Empty datagram: abandon and report a ping end
			parse_clr = 1'b1;
			pv_n      = 1'b1;
			pk_n      = EVT_PING_END;
		end else if (pos_q == POS_HDR_LO) begin
			hlo_n = data_byte;
			pos_n = last_byte ? POS_HDR_LO : POS_HDR_HI;
		end else begin
			if (pos_q == POS_HDR_HI) begin
				held_n    = hdr;
				ftime_n   = hdr;
				pos_n     = POS_BODY_A;
				frame_clr = 1'b1;
				host_n    = PHOST_W'(1);
				if (hdr == HDR_PING) begin
					kind_n = DG_PING;
				end else if (hdr == HDR_RESERVED) begin
					kind_n = DG_RESERVED;
				end else begin
					kind_n = DG_FRAMES;
					if (hdr > exp_q) begin
						pv_n    = 1'b1;
						pk_n    = EVT_LOSS;
						ptime_n = hdr;
						if (cfg.abort_on_loss) begin
							skip_n = 1'b1;
						end
					end
				end
			end else if (!skip_q) begin
				if (kind_q == DG_PING) begin
					if (pos_q == POS_BODY_A) begin
						plow_n = data_byte;
						pos_n  = POS_BODY_B;
					end else begin
						pos_n = POS_BODY_A;
						if (host_q < HOST_LIMIT) begin
							pv_n   = 1'b1;
							pk_n   = EVT_PING;
							host_n = host_q + PHOST_W'(1);
						end
					end
				end else if (kind_q == DG_FRAMES) begin
					if (!inact_q) begin
						// Gather mask bytes
						mask_n = mask_or;
						fin_n  = fin_q && (data_byte == FINISH_BYTE);
						cnt_n  = cnt_inc;
						if (cnt_inc >= mb) begin
							if (fin_n) begin
								pv_n      = 1'b1;
								pk_n      = EVT_FINISH;
								exp_n     = exp_q + 16'd1;
								ftime_n   = ftime_q + 16'd1;
								frame_clr = 1'b1;
							end else begin
								mask_n  = mask_or & PLAYER_MASK;
								inact_n = 1'b1;
								frame_done = ((mask_or & PLAYER_MASK) == '0);
							end
						end
					end else begin
						// Hand the byte to the lowest pending player
						for (int p = 0; p < NUM_PLAYERS; p++) begin
							if (one_hot[p]) begin
								acts_n[p] = data_byte;
							end
						end
						mask_n     = mask_left;
						frame_done = (mask_left == '0);
					end
					if (frame_done) begin
						snap_n = acts_n;
						pv_n   = 1'b1;
						if (ftime_q == exp_q) begin
							pk_n  = EVT_ACTION;
							exp_n = exp_q + 16'd1;
						end else begin
							pk_n = EVT_IGNORE;
						end
						ftime_n   = ftime_q + 16'd1;
						frame_clr = 1'b1;
					end
				end
			end
			// Close the datagram
			if (last_byte) begin
				if (kind_n == DG_PING) begin
					tv_n = 1'b1;
					tk_n = EVT_PING_END;
				end else if (kind_n == DG_FRAMES && !skip_n) begin
					tv_n     = 1'b1;
					tk_n     = EVT_PARSED;
					tfirst_n = held_n;
					tnext_n  = ftime_n;
				end
				parse_clr = 1'b1;
			end
		end

		if (parse_clr) begin
			pos_n     = POS_HDR_LO;
			skip_n    = 1'b0;
			host_n    = PHOST_W'(1);
			plow_n    = 8'd0;
			frame_clr = 1'b1;
		end
		if (frame_clr) begin
			mask_n  = '0;
			cnt_n   = 2'd0;
			fin_n   = 1'b1;
			inact_n = 1'b0;
			for (int p = 0; p < NUM_PLAYERS; p++) begin
				acts_n[p] = 8'd0;
			end
		end
	end

	// Parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HDR_LO;
			hlo_q   <= 8'd0;
			kind_q  <= DG_FRAMES;
			ftime_q <= 16'd0;
			exp_q   <= 16'd1;
			mask_q  <= '0;
			cnt_q   <= 2'd0;
			fin_q   <= 1'b1;
			inact_q <= 1'b0;
			host_q  <= PHOST_W'(1);
			plow_q  <= 8'd0;
			skip_q  <= 1'b0;
			held_q  <= 16'd0;
			pv_q    <= 1'b0;
			tv_q    <= 1'b0;
			for (int p = 0; p < NUM_PLAYERS; p++) begin
				acts_q[p] <= 8'd0;
			end
		end else if (cmd.load_in) begin
			pos_q   <= pos_n;
			hlo_q   <= hlo_n;
			kind_q  <= kind_n;
			ftime_q <= ftime_n;
			exp_q   <= exp_n;
			mask_q  <= mask_n;
			cnt_q   <= cnt_n;
			fin_q   <= fin_n;
			inact_q <= inact_n;
			host_q  <= host_n;
			plow_q  <= plow_n;
			skip_q  <= skip_n;
			held_q  <= held_n;
			pv_q    <= pv_n;
			tv_q    <= tv_n;
			acts_q  <= acts_n;
		end
	end

	// Pending payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pk_q     <= pk_n;
			ptime_q  <= ptime_n;
			phost_q  <= phost_n;
			pping_q  <= pping_n;
			snap_q   <= snap_n;
			tk_q     <= tk_n;
			tfirst_q <= tfirst_n;
			tnext_q  <= tnext_n;
		end
	end

	assign stat.has_prim   = pv_q;
	assign stat.prim_multi = (pk_q == EVT_ACTION);
	assign stat.has_tail   = tv_q;
	assign stat.out_free   = !ov_q || !out_stall;

	// Build the outgoing result; unused fields stay zero
	always_comb begin
		ok_n     = cmd.emit_tail ? tk_q : pk_q;
		ogt_n    = 16'd0;
		opl_n    = 3'd0;
		oact_n   = 8'd0;
		ohost_n  = 3'd0;
		oping_n  = 16'd0;
		ofirst_n = 16'd0;
		onext_n  = 16'd0;
		unique case (ok_n)
			EVT_ACTION: begin
				ogt_n  = ptime_q;
				opl_n  = cmd.act_idx;
				oact_n = snap_q[cmd.act_idx];
			end
			EVT_FINISH, EVT_IGNORE, EVT_LOSS: ogt_n = ptime_q;
			EVT_PING: begin
				ohost_n = phost_q;
				oping_n = pping_q;
			end
			EVT_PARSED: begin
				ofirst_n = tfirst_q;
				onext_n  = tnext_q;
			end
			default: ;
		endcase
	end

	// Output register: load on emit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit_prim || cmd.emit_tail) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_prim || cmd.emit_tail) begin
			ok_q     <= ok_n;
			ogt_q    <= ogt_n;
			opl_q    <= opl_n;
			oact_q   <= oact_n;
			ohost_q  <= ohost_n;
			oping_q  <= oping_n;
			ofirst_q <= ofirst_n;
			onext_q  <= onext_n;
			olast_q  <= cmd.last;
		end
	end

	assign out_valid    = ov_q;
	assign event_kind   = ok_q;
	assign game_time    = ogt_q;
	assign player_index = opl_q;
	assign action_byte  = oact_q;
	assign host_index   = ohost_q;
	assign ping_time    = oping_q;
	assign first_time   = ofirst_q;
	assign next_time    = onext_q;
	assign last_of_run  = olast_q;

endmodule

### tb/sv/tb_top.sv
// Testbench for the datagram receive parser: directed and random datagrams checked per event.
`timescale 1ns / 1ps
module tb_top;
	import adrp_pkg::*;

	localparam int ITEM_TARGET    = 260;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [PADDR_W-1:0] ADDR_MASK_LEN = {REG_MASK_BYTES, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_ABORT    = {REG_ABORT, 2'b00};

	typedef struct packed {
		event_kind_t kind;
		logic [15:0] gtime;
		logic [2:0]  player;
		logic [7:0]  act;
		logic [2:0]  host;
		logic [15:0] ping;
		logic [15:0] first;
		logic [15:0] after_time;
		logic        last;
	} parse_event_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         event_kind;
	logic [15:0]        game_time;
	logic [2:0]         player_index;
	logic [7:0]         action_byte;
	logic [2:0]         host_index;
	logic [15:0]        ping_time;
	logic [15:0]        first_time;
	logic [15:0]        next_time;
	logic               last_of_run;

	// Parser copy: configuration
	logic [1:0]  mask_len_cfg;
	logic        abort_cfg;
	// Parser copy: datagram and frame state
	logic [1:0]  rx_pos;
	logic [7:0]  rx_hdr_lo;
	dgram_kind_t rx_kind;
	logic [15:0] cur_time;
	logic [15:0] want_time;
	logic [23:0] mask_acc;
	logic [1:0]  mask_cnt;
	logic        all_ff;
	logic [7:0]  act_hold [NUM_PLAYERS];
	logic [6:0]  next_host;
	logic [7:0]  ping_lo;
	logic        drop_rest;
	logic        taking_actions;
	logic [15:0] run_start;

	parse_event_t step_events[$];
	parse_event_t pending_events[$];
	logic [7:0]   dgram_bytes[$];

	int fail_count;
	int bytes_sent;
	int random_bytes;
	int events_checked;
	int phases_run;
	int quiet_cycles;
	int kind_count [7];
	bit tx_random;
	bit rx_random;
	bit hold_flip = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	action_datagram_receive_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .game_time(game_time), .player_index(player_index),
		.action_byte(action_byte), .host_index(host_index), .ping_time(ping_time),
		.first_time(first_time), .next_time(next_time), .last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// ---------------------------------------------------------------
	// Parser copy
	// ---------------------------------------------------------------
	function void add_event(input event_kind_t kind, input logic [15:0] gt,
			input logic [2:0] pl, input logic [7:0] act, input logic [2:0] host,
			input logic [15:0] ping, input logic [15:0] first, input logic [15:0] after_t);
		parse_event_t ev;
		ev.kind       = kind;
		ev.gtime      = gt;
		ev.player     = pl;
		ev.act        = act;
		ev.host       = host;
		ev.ping       = ping;
		ev.first      = first;
		ev.after_time = after_t;
		ev.last       = 1'b0;
		step_events.push_back(ev);
	endfunction

	function void clear_frame();
		mask_acc       = '0;
		mask_cnt       = 2'd0;
		all_ff         = 1'b1;
		taking_actions = 1'b0;
		for (int p = 0; p < NUM_PLAYERS; p++)
			act_hold[p] = 8'h00;
	endfunction

	function void clear_parse();
		rx_pos    = POS_HDR_LO;
		drop_rest = 1'b0;
		next_host = 7'd1;
		ping_lo   = 8'h00;
		clear_frame();
	endfunction

	function void reset_parser();
		mask_len_cfg = 2'd1;
		abort_cfg    = 1'b0;
		rx_hdr_lo    = 8'h00;
		rx_kind      = DG_FRAMES;
		cur_time     = 16'd0;
		want_time    = 16'd1;
		run_start    = 16'd0;
		clear_parse();
	endfunction

	// Complete a frame: a timely one reports every player, any other one is ignored
	function void close_frame();
		if (cur_time == want_time) begin
			for (int p = 0; p < NUM_PLAYERS; p++)
				add_event(EVT_ACTION, cur_time, 3'(p), act_hold[p], 3'd0,
					16'd0, 16'd0, 16'd0);
			want_time = want_time + 16'd1;
		end else begin
			add_event(EVT_IGNORE, cur_time, 3'd0, 8'h00, 3'd0, 16'd0, 16'd0, 16'd0);
		end
		cur_time = cur_time + 16'd1;
		clear_frame();
	endfunction

	function void frame_byte(input logic [7:0] b);
		logic [1:0]  need;
		logic [31:0] shifted;
		logic        found;
		need = (mask_len_cfg == 2'd0) ? 2'd1 : mask_len_cfg;
		if (!taking_actions) begin
			// Collect mask bytes, low byte first
			shifted = {24'd0, b} << (8 * mask_cnt);
			mask_acc = mask_acc | shifted[23:0];
			if (b != FINISH_BYTE)
				all_ff = 1'b0;
			mask_cnt = mask_cnt + 2'd1;
			if (mask_cnt >= need) begin
				if (all_ff) begin
					add_event(EVT_FINISH, cur_time, 3'd0, 8'h00, 3'd0,
						16'd0, 16'd0, 16'd0);
					want_time = want_time + 16'd1;
					cur_time  = cur_time + 16'd1;
					clear_frame();
				end else begin
					mask_acc       = mask_acc & PLAYER_MASK;
					taking_actions = 1'b1;
					if (mask_acc == '0)
						close_frame();
				end
			end
		end else begin
			// Hand the byte to the lowest player still waiting
			found = 1'b0;
			for (int p = 0; p < NUM_PLAYERS; p++) begin
				if (!found && mask_acc[p]) begin
					act_hold[p] = b;
					mask_acc[p] = 1'b0;
					found       = 1'b1;
				end
			end
			if (mask_acc == '0)
				close_frame();
		end
	endfunction

	// Advance the parser copy by one accepted transaction and queue its events
	function void parse_byte(input logic cmd, input logic [7:0] b, input logic last);
		logic [15:0]  hdr;
		parse_event_t ev;
		step_events.delete();
		if (cmd) begin
			clear_parse();
			add_event(EVT_PING_END, 16'd0, 3'd0, 8'h00, 3'd0, 16'd0, 16'd0, 16'd0);
		end else if (rx_pos == POS_HDR_LO) begin
			rx_hdr_lo = b;
			rx_pos    = last ? POS_HDR_LO : POS_HDR_HI;
		end else begin
			if (rx_pos == POS_HDR_HI) begin
				hdr       = {b, rx_hdr_lo};
				run_start = hdr;
				cur_time  = hdr;
				rx_pos    = POS_BODY_A;
				clear_frame();
				next_host = 7'd1;
				if (hdr == HDR_PING) begin
					rx_kind = DG_PING;
				end else if (hdr == HDR_RESERVED) begin
					rx_kind = DG_RESERVED;
				end else begin
					rx_kind = DG_FRAMES;
					if (hdr > want_time) begin
						add_event(EVT_LOSS, hdr, 3'd0, 8'h00, 3'd0,
							16'd0, 16'd0, 16'd0);
						if (abort_cfg)
							drop_rest = 1'b1;
					end
				end
			end else if (!drop_rest) begin
				if (rx_kind == DG_PING) begin
					if (rx_pos == POS_BODY_A) begin
						ping_lo = b;
						rx_pos  = POS_BODY_B;
					end else begin
						rx_pos = POS_BODY_A;
						if (next_host < NUM_HOSTS) begin
							add_event(EVT_PING, 16'd0, 3'd0, 8'h00, next_host[2:0],
								{b, ping_lo}, 16'd0, 16'd0);
							next_host = next_host + 7'd1;
						end
					end
				end else if (rx_kind == DG_FRAMES) begin
					frame_byte(b);
				end
			end
			if (last) begin
				if (rx_kind == DG_PING)
					add_event(EVT_PING_END, 16'd0, 3'd0, 8'h00, 3'd0,
						16'd0, 16'd0, 16'd0);
				else if (rx_kind == DG_FRAMES && !drop_rest)
					add_event(EVT_PARSED, 16'd0, 3'd0, 8'h00, 3'd0,
						16'd0, run_start, cur_time);
				clear_parse();
			end
		end
		// Mark the final event of this transaction
		if (step_events.size() > 0) begin
			ev = step_events.pop_back();
			ev.last = 1'b1;
			step_events.push_back(ev);
		end
		while (step_events.size() > 0)
			pending_events.push_back(step_events.pop_front());
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	// Offer one transaction; called and returns just after a falling edge
	task offer_byte(input logic cmd, input logic [7:0] b, input logic last);
		int gap;
		if (tx_random && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_byte(cmd, b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task send_dgram(input bit with_last);
		for (int i = 0; i < dgram_bytes.size(); i++)
			offer_byte(1'b0, dgram_bytes[i], with_last && (i == dgram_bytes.size() - 1));
	endtask

	// Drop valid, wait for every queued event, then let the block go quiet
	task settle();
		in_valid <= 1'b0;
		while (pending_events.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (addr)
			ADDR_MASK_LEN: mask_len_cfg = value[1:0];
			ADDR_ABORT:    abort_cfg = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task set_config(input logic [1:0] mlen, input logic abort);
		settle();
		write_reg(ADDR_MASK_LEN, {30'd0, mlen});
		write_reg(ADDR_ABORT, {31'd0, abort});
	endtask

	// Receiver stall: random short/long stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_flip != hold_seen) begin
			hold_seen <= hold_flip;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (rx_random && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap() - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Result check
	// ---------------------------------------------------------------
	function void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		parse_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("result transaction with no event pending: kind %0d", event_kind);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", 16'(want.kind), 16'(event_kind));
				check_field("game_time", want.gtime, game_time);
				check_field("player_index", 16'(want.player), 16'(player_index));
				check_field("action_byte", 16'(want.act), 16'(action_byte));
				check_field("host_index", 16'(want.host), 16'(host_index));
				check_field("ping_time", want.ping, ping_time);
				check_field("first_time", want.first, first_time);
				check_field("next_time", want.after_time, next_time);
				check_field("last_of_run", 16'(want.last), 16'(last_of_run));
				kind_count[int'(want.kind)]++;
				events_checked++;
			end
		end
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("action_datagram_receive_parser_core test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Timely frames with sparse and empty masks, then a finish frame
	task test_frame_run();
		dgram_bytes = '{want_time[7:0], want_time[15:8], 8'h81, 8'hFF, 8'h00, 8'h00, 8'hFF};
		send_dgram(1'b1);
	endtask

	// One ping pair, then a lone trailing byte that is dropped
	task test_ping_list();
		dgram_bytes = '{8'hFF, 8'hFF, 8'h34, 8'h12, 8'h7F};
		send_dgram(1'b1);
	endtask

	task test_reserved();
		dgram_bytes = '{8'hFE, 8'hFF, 8'h00, 8'hAB};
		send_dgram(1'b1);
	endtask

	// Late header reports loss; frame times wrap; the cut-off frame is dropped
	task test_loss_wrap_partial();
		dgram_bytes = '{8'hFD, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 8'h11};
		send_dgram(1'b1);
	endtask

	// One-byte datagram, empty datagram, and an empty datagram cutting one short
	task test_short_datagrams();
		offer_byte(1'b0, 8'h33, 1'b1);
		offer_byte(1'b1, 8'h00, 1'b0);
		offer_byte(1'b0, 8'h22, 1'b0);
		offer_byte(1'b1, 8'hFF, 1'b1);
	endtask

	task test_config_modes();
		logic [15:0] hdr;
		// Abort after loss with three mask bytes
		set_config(2'd3, 1'b1);
		hdr = want_time + 16'd9;
		dgram_bytes = '{hdr[7:0], hdr[15:8], 8'h00, 8'h12};
		send_dgram(1'b1);
		// Zero mask length acts as one byte
		set_config(2'd0, 1'b0);
		dgram_bytes = '{want_time[7:0], want_time[15:8], 8'hFF, 8'h00};
		send_dgram(1'b1);
		// Shrink the mask length in the middle of a frame
		set_config(2'd3, 1'b0);
		dgram_bytes = '{want_time[7:0], want_time[15:8], 8'h01, 8'h00};
		send_dgram(1'b0);
		set_config(2'd1, 1'b0);
		dgram_bytes = '{8'h00, 8'h42};
		send_dgram(1'b1);
	endtask

	// Hold the receiver off while several full frames pile up behind it
	task test_backpressure();
		settle();
		hold_flip = ~hold_flip;
		dgram_bytes = '{want_time[7:0], want_time[15:8], 8'h00, 8'h00, 8'h00, 8'hFF};
		send_dgram(1'b1);
	endtask

	// Build and send one random datagram; leave_open stops a frame run part way
	task random_datagram(input bit leave_open);
		int          pick;
		int          cnt;
		int          nfr;
		int          need;
		int          cut;
		logic [15:0] hdr;
		logic [7:0]  lo;
		logic [7:0]  ub;
		bit          ff_all;
		bit          reserved;
		dgram_bytes.delete();
		reserved = 1'b0;
		pick = leave_open ? 99 : $urandom_range(0, 99);
		if (pick < 5) begin
			offer_byte(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
			random_bytes++;
			return;
		end
		if (pick < 10) begin
			// Noise: loose bytes with random ends
			cnt = $urandom_range(1, 4);
			repeat (cnt)
				offer_byte(1'b0, 8'($urandom), 1'($urandom_range(0, 3) == 0));
			random_bytes += cnt;
			return;
		end
		if (pick < 22) begin
			dgram_bytes = '{8'hFF, 8'hFF};
			cnt = $urandom_range(0, 9);
			repeat (2 * cnt)
				dgram_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 3) == 0)
				dgram_bytes.push_back(8'($urandom));
		end else if (pick < 27) begin
			reserved = 1'b1;
			dgram_bytes = '{8'hFE, 8'hFF};
			repeat ($urandom_range(0, 3))
				dgram_bytes.push_back(8'($urandom));
		end else begin
			// Frame run: mostly on time, some stale, late or near the wrap
			cnt = $urandom_range(0, 99);
			if (cnt < 70)
				hdr = want_time;
			else if (cnt < 80)
				hdr = (want_time > 16'd5) ? want_time - 16'($urandom_range(1, 5)) : 16'd0;
			else if (cnt < 92)
				hdr = want_time + 16'($urandom_range(1, 20));
			else if (cnt < 97)
				hdr = 16'($urandom);
			else
				hdr = 16'hFFFD - 16'($urandom_range(0, 2));
			dgram_bytes = '{hdr[7:0], hdr[15:8]};
			need = (mask_len_cfg == 2'd0) ? 1 : mask_len_cfg;
			nfr = $urandom_range(1, 4);
			repeat (nfr) begin
				if ($urandom_range(0, 5) == 0) begin
					repeat (need)
						dgram_bytes.push_back(FINISH_BYTE);
				end else begin
					case ($urandom_range(0, 3))
						0: lo = 8'h00;
						1: lo = 8'hFF;
						default: lo = 8'($urandom);
					endcase
					ff_all = (lo == FINISH_BYTE);
					dgram_bytes.push_back(lo);
					repeat (need - 1) begin
						ub = 8'($urandom);
						ff_all = ff_all && (ub == FINISH_BYTE);
						dgram_bytes.push_back(ub);
					end
					if (!ff_all)
						repeat ($countones(lo))
							dgram_bytes.push_back(8'($urandom));
				end
			end
			// Cut the tail to leave a partial frame
			if (leave_open)
				cut = $urandom_range(0, dgram_bytes.size() - 3);
			else if ($urandom_range(0, 7) == 0)
				cut = $urandom_range(1, 2);
			else
				cut = 0;
			while (cut > 0 && dgram_bytes.size() > 2) begin
				void'(dgram_bytes.pop_back());
				cut--;
			end
		end
		send_dgram(!leave_open);
		if (!reserved)
			random_bytes += dgram_bytes.size();
	endtask

	task test_random_phases();
		int         phase;
		int         cnt;
		logic [1:0] mlen;
		logic       abort;
		phase = 0;
		while (bytes_sent < ITEM_TARGET) begin
			case (phase)
				0: mlen = 2'd1;
				1: mlen = 2'd3;
				2: mlen = 2'd0;
				3: mlen = 2'd2;
				default: mlen = 2'($urandom_range(0, 3));
			endcase
			abort = (phase < 4) ? 1'(phase) : 1'($urandom_range(0, 1));
			set_config(mlen, abort);
			// One phase runs with no idling on either side
			tx_random = (phase != 2) && ($urandom_range(0, 4) != 0);
			rx_random = (phase != 2) && ($urandom_range(0, 4) != 0);
			cnt = $urandom_range(3, 6);
			repeat (cnt)
				if (bytes_sent < ITEM_TARGET)
					random_datagram(1'b0);
			if ($urandom_range(0, 2) == 0 && bytes_sent < ITEM_TARGET)
				random_datagram(1'b1);
			phase++;
		end
		phases_run = phase;
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		command   = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		tx_random = 1'b1;
		rx_random = 1'b1;
		fail_count     = 0;
		bytes_sent     = 0;
		random_bytes   = 0;
		events_checked = 0;
		phases_run     = 0;
		quiet_cycles   = 0;
		for (int k = 0; k < 7; k++)
			kind_count[k] = 0;
		reset_parser();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_frame_run();
		test_ping_list();
		test_reserved();
		test_loss_wrap_partial();
		test_short_datagrams();
		test_config_modes();
		test_backpressure();
		test_random_phases();
		settle();

		$display("Sent %0d bytes (%0d random over %0d config phases), checked %0d results.",
			bytes_sent, random_bytes, phases_run, events_checked);
		$display("Results: action %0d, finish %0d, ignore %0d, loss %0d,",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("  ping %0d, ping end %0d, parsed %0d.",
			kind_count[4], kind_count[5], kind_count[6]);
		if (fail_count == 0)
			$display("action_datagram_receive_parser_core test passed");
		else
			$display("action_datagram_receive_parser_core test failed");
		$finish;
	end

endmodule
